// ===== rtl/cz2x_pkg.sv =====
`default_nettype none

package cz2x_pkg;

   // line store depth, widest supported frame
   localparam int MAX_DIM = 2048;
   localparam int IDX_W   = $clog2(MAX_DIM);

   // register and coordinate widths
   localparam int CFG_W   = 12;
   localparam int CSR_A_W = 3;
   localparam int PIX_W   = 24;
   localparam int CH_W    = 8;

   // depth of the job queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // register indexes
   localparam logic [CSR_A_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_WIN_LEFT     = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_WIN_RIGHT    = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_WIN_TOP      = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_WIN_BOTTOM   = 3'd5;
   localparam logic [CSR_A_W-1:0] REG_COLOR_MODE   = 3'd6;

   typedef struct packed {
      logic            start_of_frame;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [CFG_W-1:0] out_row;
      logic [CFG_W-1:0] out_col;
      logic [CH_W-1:0]  out_red;
      logic [CH_W-1:0]  out_green;
      logic [CH_W-1:0]  out_blue;
      logic             last_of_run;
   } rsp_type;

   // configuration register set
   typedef struct packed {
      logic [CFG_W-1:0] image_width;
      logic [CFG_W-1:0] image_height;
      logic [CFG_W-1:0] win_left;
      logic [CFG_W-1:0] win_right;
      logic [CFG_W-1:0] win_top;
      logic [CFG_W-1:0] win_bottom;
      logic             color_mode;
   } cfg_type;

   // one window pixel with all the values its results need
   typedef struct packed {
      logic [CFG_W-1:0] row;
      logic [CFG_W-1:0] col;
      logic             has_up;
      logic             has_left;
      logic [PIX_W-1:0] px_diag;
      logic [PIX_W-1:0] px_up;
      logic [PIX_W-1:0] px_left;
      logic [PIX_W-1:0] px_cur;
   } job_type;

   // per channel truncated mean, red in the low byte
   function automatic logic [PIX_W-1:0] px_mean(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] res;
      logic [CH_W:0]    sum;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         sum = {1'b0, a[k*CH_W +: CH_W]} + {1'b0, b[k*CH_W +: CH_W]};
         res[k*CH_W +: CH_W] = sum[CH_W:1];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cz2x_front.sv =====
`default_nettype none

module cz2x_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cz2x_pkg::cfg_type cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cz2x_pkg::req_type req_data,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output cz2x_pkg::job_type     push_data
);

   // position counters
   logic [cz2x_pkg::CFG_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [cz2x_pkg::CFG_W-1:0] col_eff, row_eff;
   logic [cz2x_pkg::CFG_W:0]   col_sum, row_sum;

   // pixel context
   logic [cz2x_pkg::PIX_W-1:0] left_ff, ul_ff, up_ff, cur;

   // stage holding a window pixel while the store read completes
   logic                       s1_valid_ff, s1_valid_in;
   logic [cz2x_pkg::CFG_W-1:0] s1_row_ff, s1_col_ff;
   logic [cz2x_pkg::PIX_W-1:0] s1_cur_ff, s1_left_ff;

   // previous window row
   logic [cz2x_pkg::PIX_W-1:0] store_mem [cz2x_pkg::MAX_DIM];

   logic                       win_ok, frame_ok, accept, push;
   logic [cz2x_pkg::CFG_W-1:0] c_rel, r_rel;
   logic [cz2x_pkg::IDX_W-1:0] store_idx;
   logic [cz2x_pkg::PIX_W-1:0] px_left_mean;

   // classification of the incoming pixel
   always_comb begin
      col_eff  = req_data.start_of_frame ? '0 : col_ff;
      row_eff  = req_data.start_of_frame ? '0 : row_ff;
      frame_ok = (cfg.win_left < cfg.win_right) && (cfg.win_right <= cfg.image_width) &&
                 (cfg.win_top < cfg.win_bottom) && (cfg.win_bottom <= cfg.image_height) &&
                 (32'(cfg.image_width) <= cz2x_pkg::MAX_DIM) &&
                 (32'(cfg.image_height) <= cz2x_pkg::MAX_DIM);
      win_ok   = frame_ok && (col_eff >= cfg.win_left) && (col_eff < cfg.win_right) &&
                 (row_eff >= cfg.win_top) && (row_eff < cfg.win_bottom);
      c_rel     = col_eff - cfg.win_left;
      r_rel     = row_eff - cfg.win_top;
      store_idx = cz2x_pkg::IDX_W'(c_rel);
      cur = {(cfg.color_mode ? req_data.blue  : 8'd0),
             (cfg.color_mode ? req_data.green : 8'd0),
             req_data.red};
   end

   // counter advance with wrap at the frame edges
   always_comb begin
      col_sum = {1'b0, col_eff} + 1'b1;
      row_sum = {1'b0, row_eff} + 1'b1;
      col_in  = col_sum[cz2x_pkg::CFG_W-1:0];
      row_in  = row_eff;
      if (col_sum >= {1'b0, cfg.image_width}) begin
         col_in = '0;
         if (row_sum >= {1'b0, cfg.image_height}) begin
            row_in = '0;
         end else begin
            row_in = row_sum[cz2x_pkg::CFG_W-1:0];
         end
      end
   end

   // handshake between input, stage and queue
   always_comb begin
      push        = s1_valid_ff && push_ready;
      req_ready   = !s1_valid_ff || push_ready;
      accept      = req_valid && req_ready;
      s1_valid_in = accept ? win_ok : (s1_valid_ff && !push);
      push_valid  = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         ul_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            if (win_ok) begin
               left_ff <= cur;
            end
         end
         if (push) begin
            ul_ff <= up_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept && win_ok) begin
         s1_row_ff  <= r_rel;
         s1_col_ff  <= c_rel;
         s1_cur_ff  <= cur;
         s1_left_ff <= left_ff;
      end
   end

   // line store: old entry read out, current pixel written in its place
   always_ff @(posedge clock) begin
      if (accept && win_ok) begin
         up_ff                <= store_mem[store_idx];
         store_mem[store_idx] <= cur;
      end
   end

   // interpolated values for the queue
   always_comb begin
      px_left_mean       = cz2x_pkg::px_mean(s1_left_ff, s1_cur_ff);
      push_data.row      = s1_row_ff;
      push_data.col      = s1_col_ff;
      push_data.has_up   = (s1_row_ff != '0);
      push_data.has_left = (s1_col_ff != '0);
      push_data.px_cur   = s1_cur_ff;
      push_data.px_left  = px_left_mean;
      push_data.px_up    = cz2x_pkg::px_mean(up_ff, s1_cur_ff);
      push_data.px_diag  = cz2x_pkg::px_mean(cz2x_pkg::px_mean(ul_ff, up_ff), px_left_mean);
   end

endmodule

`default_nettype wire

// ===== rtl/cz2x_queue.sv =====
`default_nettype none

module cz2x_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire cz2x_pkg::job_type push_data,
   output logic                  head_valid,
   input  wire logic             pop,
   output cz2x_pkg::job_type     head_data
);

   cz2x_pkg::job_type           slot_ff [cz2x_pkg::QDEPTH];
   logic [cz2x_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [cz2x_pkg::QCNT_W-1:0] count_ff;
   logic                        do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != cz2x_pkg::QCNT_W'(cz2x_pkg::QDEPTH));
      head_valid = (count_ff != '0);
      head_data  = slot_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop && head_valid;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == cz2x_pkg::QDEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == cz2x_pkg::QDEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // job slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cz2x_back.sv =====
`default_nettype none

module cz2x_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire cz2x_pkg::job_type head_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cz2x_pkg::rsp_type     rsp_data
);

   // result order within one window pixel
   localparam logic [1:0] PH_DIAG = 2'd0;
   localparam logic [1:0] PH_UP   = 2'd1;
   localparam logic [1:0] PH_LEFT = 2'd2;
   localparam logic [1:0] PH_CUR  = 2'd3;

   logic [1:0]                 phase_ff, phase_in, sel;
   logic                       rsp_valid_ff, rsp_valid_in, load;
   cz2x_pkg::rsp_type          rsp_ff, rsp_in;
   logic [cz2x_pkg::CFG_W-1:0] row_even, col_even, row_odd, col_odd;

   // next result still owed by the head job
   always_comb begin
      priority if (phase_ff == PH_DIAG && head_data.has_up && head_data.has_left) begin
         sel = PH_DIAG;
      end else if ((phase_ff == PH_DIAG || phase_ff == PH_UP) && head_data.has_up) begin
         sel = PH_UP;
      end else if (phase_ff != PH_CUR && head_data.has_left) begin
         sel = PH_LEFT;
      end else begin
         sel = PH_CUR;
      end
   end

   // result build
   always_comb begin
      row_even = cz2x_pkg::CFG_W'({head_data.row, 1'b0});
      col_even = cz2x_pkg::CFG_W'({head_data.col, 1'b0});
      row_odd  = row_even - 1'b1;
      col_odd  = col_even - 1'b1;
      rsp_in.last_of_run = 1'b0;
      unique case (sel)
         PH_DIAG: begin
            rsp_in.out_row = row_odd;
            rsp_in.out_col = col_odd;
            {rsp_in.out_blue, rsp_in.out_green, rsp_in.out_red} = head_data.px_diag;
         end
         PH_UP: begin
            rsp_in.out_row = row_odd;
            rsp_in.out_col = col_even;
            {rsp_in.out_blue, rsp_in.out_green, rsp_in.out_red} = head_data.px_up;
         end
         PH_LEFT: begin
            rsp_in.out_row = row_even;
            rsp_in.out_col = col_odd;
            {rsp_in.out_blue, rsp_in.out_green, rsp_in.out_red} = head_data.px_left;
         end
         default: begin
            rsp_in.out_row     = row_even;
            rsp_in.out_col     = col_even;
            rsp_in.last_of_run = 1'b1;
            {rsp_in.out_blue, rsp_in.out_green, rsp_in.out_red} = head_data.px_cur;
         end
      endcase
   end

   // output register load and queue pop
   always_comb begin
      load         = head_valid && (!rsp_valid_ff || rsp_ready);
      pop          = load && (sel == PH_CUR);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      phase_in     = phase_ff;
      if (load) begin
         phase_in = (sel == PH_CUR) ? PH_DIAG : sel + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DIAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/crop_zoom_2x_interpolate_unit.sv =====
// Crop and 2x zoom of a raster pixel stream, gray or RGB.
// req_ channel: one pixel per transfer in raster order, start_of_frame on the
// first pixel of a frame. rsp_ channel: one upscaled pixel per transfer with
// its row and column, last_of_run on the final result of an input pixel.
// csr_ port: register writes, taken at once; write only while the block idles.
// A window pixel gives one to four results, an outside pixel none.
// The first result of a pixel passes the stage register, a queue slot and the
// output register; the rest follow one per cycle while rsp_ready is high, so a
// window pixel holds the back end for one to four results. Pixels outside the
// window pass one per cycle while req_ready is high. A two-entry job queue
// lets the front take pixels while the back drains earlier ones.
// The line store is a single-port memory of MAX_DIM entries, read and written
// once per window pixel; it needs no clearing after reset.
// Reset: registers return to their defaults, counters and queue empty.
// When rsp_ready is low the output register holds, the queue fills and then
// req_ready drops.
`default_nettype none

module crop_zoom_2x_interpolate_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire cz2x_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output cz2x_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [cz2x_pkg::CSR_A_W-1:0]  csr_index,
   input  wire logic [cz2x_pkg::CFG_W-1:0]    csr_wdata
);

   cz2x_pkg::cfg_type cfg_ff;
   cz2x_pkg::job_type push_data, head_data;
   logic              push_valid, push_ready, head_valid, pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 12'd2048;
         cfg_ff.image_height <= 12'd2048;
         cfg_ff.win_left     <= 12'd0;
         cfg_ff.win_right    <= 12'd2;
         cfg_ff.win_top      <= 12'd0;
         cfg_ff.win_bottom   <= 12'd2;
         cfg_ff.color_mode   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            cz2x_pkg::REG_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            cz2x_pkg::REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            cz2x_pkg::REG_WIN_LEFT:     cfg_ff.win_left     <= csr_wdata;
            cz2x_pkg::REG_WIN_RIGHT:    cfg_ff.win_right    <= csr_wdata;
            cz2x_pkg::REG_WIN_TOP:      cfg_ff.win_top      <= csr_wdata;
            cz2x_pkg::REG_WIN_BOTTOM:   cfg_ff.win_bottom   <= csr_wdata;
            cz2x_pkg::REG_COLOR_MODE:   cfg_ff.color_mode   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // classification, line store and interpolation
   cz2x_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // job queue
   cz2x_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   // result sequencer and output register
   cz2x_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_END    = 264;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   cz2x_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   cz2x_pkg::rsp_type              rsp_data;
   logic                           csr_we = 1'b0;
   logic [cz2x_pkg::CSR_A_W-1:0]   csr_index = '0;
   logic [cz2x_pkg::CFG_W-1:0]     csr_wdata = '0;

   // stimulus and checking state
   cz2x_pkg::rsp_type              upscaled_q[$];
   int                             fail_count = 0;
   int                             cycle_count = 0;
   int                             items_sent = 0;
   bit                             sender_idling = 1'b1;
   bit                             sink_stalls = 1'b1;
   int                             stall_left = 0;

   // shadow of the block: registers, raster position, line store, neighbours
   cz2x_pkg::cfg_type              shadow_cfg;
   int                             col_pos = 0;
   int                             row_pos = 0;
   logic [cz2x_pkg::PIX_W-1:0]     line_store [cz2x_pkg::MAX_DIM];
   logic [cz2x_pkg::PIX_W-1:0]     left_pixel = '0;
   logic [cz2x_pkg::PIX_W-1:0]     diag_pixel = '0;

   crop_zoom_2x_interpolate_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // truncated mean of two pixels, per channel
   function automatic logic [cz2x_pkg::PIX_W-1:0] half_sum(
         input logic [cz2x_pkg::PIX_W-1:0] a, input logic [cz2x_pkg::PIX_W-1:0] b);
      logic [cz2x_pkg::PIX_W-1:0] avg;
      for (int ch = 0; ch < 3; ch++)
         avg[ch*cz2x_pkg::CH_W +: cz2x_pkg::CH_W] =
            (a[ch*cz2x_pkg::CH_W +: cz2x_pkg::CH_W] >> 1) +
            (b[ch*cz2x_pkg::CH_W +: cz2x_pkg::CH_W] >> 1) +
            (a[ch*cz2x_pkg::CH_W] & b[ch*cz2x_pkg::CH_W]);
      return avg;
   endfunction

   function automatic void queue_result(input int row, input int col,
                                        input logic [cz2x_pkg::PIX_W-1:0] pix,
                                        input bit last);
      cz2x_pkg::rsp_type res;
      res.out_row     = row[cz2x_pkg::CFG_W-1:0];
      res.out_col     = col[cz2x_pkg::CFG_W-1:0];
      res.out_red     = pix[cz2x_pkg::CH_W-1:0];
      res.out_green   = pix[2*cz2x_pkg::CH_W-1:cz2x_pkg::CH_W];
      res.out_blue    = pix[3*cz2x_pkg::CH_W-1:2*cz2x_pkg::CH_W];
      res.last_of_run = last;
      upscaled_q.push_back(res);
   endfunction

   // window is usable only when it lies inside a frame the line store can hold
   function automatic bit window_open();
      return shadow_cfg.win_left < shadow_cfg.win_right &&
             shadow_cfg.win_right <= shadow_cfg.image_width &&
             shadow_cfg.win_top < shadow_cfg.win_bottom &&
             shadow_cfg.win_bottom <= shadow_cfg.image_height &&
             shadow_cfg.image_width <= cz2x_pkg::MAX_DIM &&
             shadow_cfg.image_height <= cz2x_pkg::MAX_DIM;
   endfunction

   // upscaled results of one accepted pixel
   function automatic void predict_pixel(input cz2x_pkg::req_type px);
      logic [cz2x_pkg::PIX_W-1:0] cur;
      logic [cz2x_pkg::PIX_W-1:0] up;
      int                         c;
      int                         r;
      cur = {16'h0000, px.red};
      if (shadow_cfg.color_mode)
         cur = {px.blue, px.green, px.red};
      if (px.start_of_frame) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (window_open() && col_pos >= shadow_cfg.win_left && col_pos < shadow_cfg.win_right &&
          row_pos >= shadow_cfg.win_top && row_pos < shadow_cfg.win_bottom) begin
         c  = col_pos - shadow_cfg.win_left;
         r  = row_pos - shadow_cfg.win_top;
         up = line_store[c];
         if (r > 0 && c > 0)
            queue_result(2*r - 1, 2*c - 1,
                         half_sum(half_sum(diag_pixel, up), half_sum(left_pixel, cur)), 1'b0);
         if (r > 0)
            queue_result(2*r - 1, 2*c, half_sum(up, cur), 1'b0);
         if (c > 0)
            queue_result(2*r, 2*c - 1, half_sum(left_pixel, cur), 1'b0);
         queue_result(2*r, 2*c, cur, 1'b1);
         diag_pixel    = up;
         line_store[c] = cur;
         left_pixel    = cur;
      end
      // raster position, zero size behaves as one
      col_pos++;
      if (col_pos >= shadow_cfg.image_width) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= shadow_cfg.image_height)
            row_pos = 0;
      end
   endfunction

   // result sink with random stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      cz2x_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (upscaled_q.size() == 0) begin
            $display("%0t: result expected none actual row %0d col %0d", $time,
                     rsp_data.out_row, rsp_data.out_col);
            fail_count++;
         end else begin
            want = upscaled_q.pop_front();
            check_field("out_row", 32'(want.out_row), 32'(rsp_data.out_row));
            check_field("out_col", 32'(want.out_col), 32'(rsp_data.out_col));
            check_field("out_red", 32'(want.out_red), 32'(rsp_data.out_red));
            check_field("out_green", 32'(want.out_green), 32'(rsp_data.out_green));
            check_field("out_blue", 32'(want.out_blue), 32'(rsp_data.out_blue));
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_data.last_of_run));
         end
      end
   end

   // one pixel transfer, predicted on acceptance
   task automatic send_pixel(input bit sof, input logic [cz2x_pkg::CH_W-1:0] red,
                             input logic [cz2x_pkg::CH_W-1:0] green,
                             input logic [cz2x_pkg::CH_W-1:0] blue);
      cz2x_pkg::req_type px;
      px.start_of_frame = sof;
      px.red            = red;
      px.green          = green;
      px.blue           = blue;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(px);
      items_sent++;
   endtask

   // raster stream with random content, optional stray frame starts
   task automatic stream_frame(input int count, input bit noise);
      bit sof;
      for (int i = 0; i < count; i++) begin
         sof = (i == 0) || (noise && $urandom_range(0, 29) == 0);
         send_pixel(sof, cz2x_pkg::CH_W'($urandom_range(0, 255)),
                    cz2x_pkg::CH_W'($urandom_range(0, 255)),
                    cz2x_pkg::CH_W'($urandom_range(0, 255)));
      end
   endtask

   // hold off until every predicted result has come and the block settles
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (upscaled_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cz2x_pkg::CSR_A_W-1:0] idx,
                            input logic [cz2x_pkg::CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic write_config(input int w, input int h, input int l, input int r,
                               input int t, input int b, input int mode);
      write_reg(cz2x_pkg::REG_IMAGE_WIDTH, cz2x_pkg::CFG_W'(w));
      write_reg(cz2x_pkg::REG_IMAGE_HEIGHT, cz2x_pkg::CFG_W'(h));
      write_reg(cz2x_pkg::REG_WIN_LEFT, cz2x_pkg::CFG_W'(l));
      write_reg(cz2x_pkg::REG_WIN_RIGHT, cz2x_pkg::CFG_W'(r));
      write_reg(cz2x_pkg::REG_WIN_TOP, cz2x_pkg::CFG_W'(t));
      write_reg(cz2x_pkg::REG_WIN_BOTTOM, cz2x_pkg::CFG_W'(b));
      write_reg(cz2x_pkg::REG_COLOR_MODE, cz2x_pkg::CFG_W'(mode & 1));
      csr_we <= 1'b0;
      shadow_cfg.image_width  = cz2x_pkg::CFG_W'(w);
      shadow_cfg.image_height = cz2x_pkg::CFG_W'(h);
      shadow_cfg.win_left     = cz2x_pkg::CFG_W'(l);
      shadow_cfg.win_right    = cz2x_pkg::CFG_W'(r);
      shadow_cfg.win_top      = cz2x_pkg::CFG_W'(t);
      shadow_cfg.win_bottom   = cz2x_pkg::CFG_W'(b);
      shadow_cfg.color_mode   = mode[0];
      @(posedge clock);
   endtask

   // default window on a 2048 wide gray frame, top row only
   task automatic test_reset_defaults();
      stream_frame(4, 1'b0);
   endtask

   // gray 3x3, channel extremes, green and blue must be ignored
   task automatic test_gray_directed();
      wait_idle();
      write_config(3, 3, 0, 3, 0, 3, 0);
      send_pixel(1'b1, 8'd0, 8'hff, 8'hff);
      send_pixel(1'b0, 8'd255, 8'h00, 8'h5a);
      send_pixel(1'b0, 8'd1, 8'ha5, 8'h00);
      send_pixel(1'b0, 8'd254, 8'h00, 8'h00);
      send_pixel(1'b0, 8'd128, 8'hff, 8'hff);
      send_pixel(1'b0, 8'd127, 8'h12, 8'h34);
      send_pixel(1'b0, 8'd255, 8'h00, 8'h00);
      send_pixel(1'b0, 8'd0, 8'hff, 8'hff);
      send_pixel(1'b0, 8'd255, 8'hff, 8'hff);
   endtask

   // rgb 3x2, truncation of odd sums on every channel
   task automatic test_rgb_directed();
      wait_idle();
      write_config(3, 2, 0, 3, 0, 2, 1);
      send_pixel(1'b1, 8'd255, 8'd0, 8'd128);
      send_pixel(1'b0, 8'd0, 8'd255, 8'd127);
      send_pixel(1'b0, 8'd1, 8'd1, 8'd1);
      send_pixel(1'b0, 8'd254, 8'd255, 8'd0);
      send_pixel(1'b0, 8'd255, 8'd254, 8'd1);
      send_pixel(1'b0, 8'd0, 8'd0, 8'd255);
   endtask

   // offset window, frame restart in mid-frame, single pixel and single column
   task automatic test_window_offsets();
      wait_idle();
      write_config(5, 4, 1, 4, 1, 3, 1);
      stream_frame(20, 1'b0);
      stream_frame(7, 1'b0);
      stream_frame(20, 1'b0);
      wait_idle();
      write_config(1, 1, 0, 1, 0, 1, 0);
      stream_frame(3, 1'b0);
      wait_idle();
      write_config(4, 3, 2, 3, 0, 3, 1);
      stream_frame(12, 1'b0);
   endtask

   // windows that must give no results at all
   task automatic test_invalid_windows();
      wait_idle();
      write_config(4, 4, 2, 2, 0, 2, 1);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(4, 4, 0, 5, 0, 2, 1);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(4, 4, 0, 2, 3, 1, 0);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(4, 4, 0, 2, 0, 5, 1);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(4, 4, 4095, 2, 0, 2, 0);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(4095, 4, 0, 2, 0, 2, 1);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(4, 4095, 0, 2, 0, 2, 0);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(0, 4, 0, 0, 0, 2, 1);
      stream_frame(5, 1'b0);
      wait_idle();
      write_config(4, 0, 0, 2, 0, 0, 0);
      stream_frame(5, 1'b0);
   endtask

   // largest frame the line store holds, then one column past it
   task automatic test_extreme_sizes();
      wait_idle();
      write_config(cz2x_pkg::MAX_DIM, cz2x_pkg::MAX_DIM, 0, cz2x_pkg::MAX_DIM,
                   0, cz2x_pkg::MAX_DIM, 1);
      stream_frame(6, 1'b0);
      wait_idle();
      write_config(cz2x_pkg::MAX_DIM + 1, 2, 0, 2, 0, 2, 1);
      stream_frame(4, 1'b0);
   endtask

   // random settings, mostly well-formed frames, some cut short or broken
   task automatic test_random_frames();
      int w;
      int h;
      int l;
      int r;
      int t;
      int b;
      while (items_sent < RANDOM_END) begin
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(10, 24);
            h = $urandom_range(1, 2);
         end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
         end
         l = $urandom_range(0, w - 1);
         r = $urandom_range(l + 1, w);
         t = $urandom_range(0, h - 1);
         b = $urandom_range(t + 1, h);
         if ($urandom_range(0, 7) == 0) begin
            l = $urandom_range(0, 15);
            r = $urandom_range(0, 15);
            t = $urandom_range(0, 15);
            b = $urandom_range(0, 15);
         end
         wait_idle();
         write_config(w, h, l, r, t, b, $urandom_range(0, 1));
         repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 5) == 0)
               stream_frame($urandom_range(1, w * h), 1'b1);
            stream_frame(w * h, 1'b1);
            // sender sometimes holds off until the pipeline is empty
            if ($urandom_range(0, 3) == 0)
               wait_idle();
         end
      end
   endtask

   // closing stretch at full rate on both sides
   task automatic test_unthrottled();
      wait_idle();
      sender_idling = 1'b0;
      sink_stalls   = 1'b0;
      write_config(6, 5, 0, 6, 0, 5, 1);
      stream_frame(30, 1'b0);
      wait_idle();
      write_config(4, 4, 1, 3, 1, 4, 0);
      stream_frame(16, 1'b0);
   endtask

   initial begin
      shadow_cfg.image_width  = 12'd2048;
      shadow_cfg.image_height = 12'd2048;
      shadow_cfg.win_left     = 12'd0;
      shadow_cfg.win_right    = 12'd2;
      shadow_cfg.win_top      = 12'd0;
      shadow_cfg.win_bottom   = 12'd2;
      shadow_cfg.color_mode   = 1'b0;
      for (int i = 0; i < cz2x_pkg::MAX_DIM; i++)
         line_store[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_gray_directed();
      test_rgb_directed();
      test_window_offsets();
      test_invalid_windows();
      test_extreme_sizes();
      test_random_frames();
      test_unthrottled();
      wait_idle();
      if (fail_count == 0 && upscaled_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
